/* sv/ymp_pkg.sv */
package ymp_pkg;

  // Protocol bytes
  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_EOT = 8'h04;

  // Result event codes
  localparam logic [2:0] EV_DATA  = 3'd0;
  localparam logic [2:0] EV_GOOD  = 3'd1;
  localparam logic [2:0] EV_BAD   = 3'd2;
  localparam logic [2:0] EV_EOT   = 3'd3;
  localparam logic [2:0] EV_ABORT = 3'd4;

  // One result beat as it leaves the block
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  packet_number;
    logic [10:0] block_size;
    logic        last;
  } res_t;

  // Results produced by one input item, oldest in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

/* sv/ymp_parser.sv */
module ymp_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           kind,
  input  logic [7:0]     byte_value,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    timeout_ticks,
  input  logic [1:0]     room,
  output logic           advance,
  output ymp_pkg::push_t push
);
  import ymp_pkg::*;

  localparam logic [10:0] SIZE_SHORT = 11'd128;
  localparam logic [10:0] SIZE_LONG  = 11'd1024;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    PH_HUNT, PH_NUM, PH_INV, PH_DATA, PH_CRCH, PH_CRCL
  } phase_t;

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // input holding register
  logic        held;
  logic        hold_kind;
  logic [7:0]  hold_byte;

  // parser state
  phase_t      phase, phase_next, cur_phase;
  logic        long_block, long_next;
  logic [7:0]  block_number, number_next;
  logic [10:0] bytes_received, count_next;
  logic [15:0] running_crc, crc_next;
  logic [7:0]  crc_high_byte, crc_hi_next;
  logic [15:0] idle_count, idle_next;
  logic [15:0] timeout_reg;

  logic        timed_out;
  logic        do_abort;
  logic        main_vld;
  logic [10:0] size_now;
  res_t        abort_res;
  res_t        main_res;

  assign cfg_ready = 1'b1;
  assign advance   = held && (push.cnt <= room);
  assign in_stall  = held && !advance;

  // next state and results for the held beat
  always_comb begin
    timed_out = idle_count >= timeout_reg;
    do_abort  = timed_out && (phase != PH_HUNT);
    cur_phase = timed_out ? PH_HUNT : phase;
    size_now  = long_block ? SIZE_LONG : SIZE_SHORT;

    phase_next  = phase;
    long_next   = long_block;
    number_next = block_number;
    count_next  = bytes_received;
    crc_next    = running_crc;
    crc_hi_next = crc_high_byte;
    idle_next   = idle_count;

    abort_res.event_res     = EV_ABORT;
    abort_res.data_byte     = '0;
    abort_res.byte_index    = '0;
    abort_res.packet_number = block_number;
    abort_res.block_size    = size_now;
    abort_res.last          = 1'b0;

    main_vld                = 1'b0;
    main_res.event_res      = EV_DATA;
    main_res.data_byte      = '0;
    main_res.byte_index     = '0;
    main_res.packet_number  = block_number;
    main_res.block_size     = size_now;
    main_res.last           = 1'b1;

    if (hold_kind) begin
      // tick: saturating idle counter
      if (idle_count < timeout_reg) begin
        idle_next = idle_count + 16'd1;
      end
    end else begin
      idle_next  = '0;
      phase_next = cur_phase;
      unique case (cur_phase)
        PH_NUM: begin
          number_next = hold_byte;
          phase_next  = PH_INV;
        end
        PH_INV: begin
          phase_next = (hold_byte == ~block_number) ? PH_DATA : PH_HUNT;
        end
        PH_DATA: begin
          main_vld            = 1'b1;
          main_res.event_res  = EV_DATA;
          main_res.data_byte  = hold_byte;
          main_res.byte_index = bytes_received[9:0];
          crc_next            = crc_step(running_crc, hold_byte);
          count_next          = bytes_received + 11'd1;
          if (count_next >= size_now) begin
            phase_next = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_hi_next = hold_byte;
          phase_next  = PH_CRCL;
        end
        PH_CRCL: begin
          main_vld           = 1'b1;
          main_res.event_res = ({crc_high_byte, hold_byte} == running_crc) ? EV_GOOD : EV_BAD;
          phase_next         = PH_HUNT;
        end
        default: begin
          // header hunt
          if (hold_byte == CODE_SOH || hold_byte == CODE_STX) begin
            long_next  = (hold_byte == CODE_STX);
            count_next = '0;
            crc_next   = '0;
            phase_next = PH_NUM;
          end else if (hold_byte == CODE_EOT) begin
            main_vld               = 1'b1;
            main_res.event_res     = EV_EOT;
            main_res.packet_number = '0;
            main_res.block_size    = '0;
            phase_next             = PH_HUNT;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end

    // pack results in order, last flag on the final one
    push.cnt     = hold_kind ? 2'd0 : ({1'b0, do_abort} + {1'b0, main_vld});
    push.r0      = do_abort ? abort_res : main_res;
    push.r0.last = (push.cnt == 2'd1);
    push.r1      = main_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held           <= 1'b0;
      phase          <= PH_HUNT;
      long_block     <= 1'b0;
      block_number   <= '0;
      bytes_received <= '0;
      running_crc    <= '0;
      crc_high_byte  <= '0;
      idle_count     <= '1;
      timeout_reg    <= TIMEOUT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_reg <= timeout_ticks;
      end
      if (in_valid && !in_stall) begin
        held <= 1'b1;
      end else if (advance) begin
        held <= 1'b0;
      end
      if (advance) begin
        phase          <= phase_next;
        long_block     <= long_next;
        block_number   <= number_next;
        bytes_received <= count_next;
        running_crc    <= crc_next;
        crc_high_byte  <= crc_hi_next;
        idle_count     <= idle_next;
      end
    end
  end

  // beat payload capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_kind <= kind;
      hold_byte <= byte_value;
    end
  end

endmodule

/* sv/ymp_out_fifo.sv */
module ymp_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_en,
  input  ymp_pkg::push_t push,
  output logic [1:0]     room,
  output logic           out_valid,
  input  logic           out_stall,
  output ymp_pkg::res_t  head
);
  import ymp_pkg::*;

  // DEPTH is a power of two, at least 2
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] free_slots;
  logic [1:0]       n_wr;
  logic             pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign n_wr       = push_en ? push.cnt : 2'd0;
  assign free_slots = DEPTH_C - count;
  assign room       = (free_slots >= CNT_W'(2)) ? 2'd2 : free_slots[1:0];
  assign head       = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_wr);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(n_wr) - CNT_W'(pop);
    end
  end

  // storage, up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (n_wr == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.r1;
    end
  end

endmodule

/* sv/ymodem_packet_parser_top.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind, byte_value
// out       output     out_valid / out_stall event_res, data_byte, byte_index,
//                                           packet_number, block_size, last
// cfg       input      cfg_valid / cfg_ready timeout_ticks
//
// One input beat per cycle while in_stall is low; the parser step sits
// between the input register and a small result queue. A beat that yields
// two results (abort followed by its own result) needs two output beats, so
// the sustained rate is set by the queue drain: one result per cycle while
// out_stall is low. Synchronous active-high reset; parser returns to header
// hunt, idle count saturated, timeout 1000. in_stall rises when the queue lacks room.
module ymodem_packet_parser_top #(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [9:0]  byte_index,
  output logic [7:0]  packet_number,
  output logic [10:0] block_size,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] timeout_ticks
);
  import ymp_pkg::*;

  push_t      push;
  res_t       head;
  logic       advance;
  logic [1:0] room;

  ymp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .byte_value    (byte_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .timeout_ticks (timeout_ticks),
    .room          (room),
    .advance       (advance),
    .push          (push)
  );

  ymp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (advance),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_res     = head.event_res;
  assign data_byte     = head.data_byte;
  assign byte_index    = head.byte_index;
  assign packet_number = head.packet_number;
  assign block_size    = head.block_size;
  assign last          = head.last;

endmodule

/* dv/ymodem_packet_parser_top_tb.sv */
`timescale 1ns / 100ps

module ymodem_packet_parser_top_tb;
  import ymp_pkg::*;

  // Beat kinds
  localparam logic       K_BYTE = 1'b0;
  localparam logic       K_TICK = 1'b1;

  // Packet damage applied by the stimulus
  localparam int FLAW_NONE = 0;
  localparam int FLAW_CRC  = 1;
  localparam int FLAW_DATA = 2;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_SLACK = 8;
  localparam int STRETCH_ITEMS = 30;

  typedef enum logic [2:0] {
    S_HUNT, S_BLOCK, S_BLOCK_INV, S_PAYLOAD, S_CRC_MSB, S_CRC_LSB
  } parse_state_t;

  // Directed table row: either a config write or one input beat; typed rows
  // carry their expectation (none or one result), the rest use the predictor
  typedef struct packed {
    logic        kind;
    logic [7:0]  val;
    logic        typed;
    logic        one_res;
    logic [2:0]  ev;
    logic [7:0]  num;
    logic [10:0] size;
    logic        is_cfg;
    logic [15:0] cfg_val;
  } dir_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam logic ONE   = 1'b1;
  localparam logic NONE  = 1'b0;

  localparam int NDIR = 27;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    // fresh from reset: lone EOT, ignored bytes, tick
    '{K_BYTE, CODE_EOT, TYPED, ONE,  EV_EOT,   8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h00,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'hFF,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_TICK, 8'hFF,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    // short frame, block 0xFF, a few payload bytes across a tick
    '{K_BYTE, CODE_SOH, TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'hFF,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h00,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h00,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'hFF,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_TICK, 8'h00,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h80,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    // shortest timeout: one tick mid-packet, then EOT gives abort plus eot
    '{K_BYTE, 8'h00,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b1, 16'd1},
    '{K_TICK, 8'h5A,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, CODE_EOT, PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    // bad complement drops silently back to hunt
    '{K_BYTE, CODE_STX, TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h00,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h00,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h55,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    // timeout before the block number: abort reports the old number
    '{K_BYTE, CODE_SOH, TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_TICK, 8'h33,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h03,    TYPED, ONE,  EV_ABORT, 8'h00, 11'd128,  1'b0, 16'd0},
    // long frame cut by a timeout, restart header follows the abort
    '{K_BYTE, CODE_STX, TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'h12,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'hED,    TYPED, NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, 8'hA5,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_TICK, 8'hC3,    PRED,  NONE, EV_DATA,  8'h00, 11'd0,    1'b0, 16'd0},
    '{K_BYTE, CODE_SOH, TYPED, ONE,  EV_ABORT, 8'h12, 11'd1024, 1'b0, 16'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = K_BYTE;
  logic [7:0]  byte_value = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [9:0]  byte_index;
  logic [7:0]  packet_number;
  logic [10:0] block_size;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] timeout_ticks = 16'd0;

  ymodem_packet_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .packet_number (packet_number),
    .block_size    (block_size),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .timeout_ticks (timeout_ticks)
  );

  always #5 clk = ~clk;

  // Predicted parser state
  parse_state_t pstate = S_HUNT;
  logic         long_blk = 1'b0;
  logic [7:0]   blk_num = 8'h00;
  logic [10:0]  rx_count = 11'd0;
  logic [15:0]  crc_acc = 16'h0000;
  logic [7:0]   crc_hi = 8'h00;
  logic [15:0]  idle_count = 16'hFFFF;
  logic [15:0]  tick_limit = 16'd1000;

  res_t step_events [$];
  res_t owed_events [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   fed_items = 0;
  bit   calm = 1'b0;
  int   stall_left = 0;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] c,
                                                    input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
    return x;
  endfunction

  function automatic void add_event(input logic [2:0] ev, input logic [7:0] d,
                                    input logic [9:0] idx, input logic [7:0] num,
                                    input logic [10:0] sz);
    res_t r;
    r.event_res     = ev;
    r.data_byte     = d;
    r.byte_index    = idx;
    r.packet_number = num;
    r.block_size    = sz;
    r.last          = 1'b0;
    step_events.push_back(r);
  endfunction

  // Advance the predicted parser by one beat; results land in step_events
  function automatic void parse_beat(input logic k, input logic [7:0] b);
    logic [10:0] sz;
    step_events.delete();
    sz = long_blk ? 11'd1024 : 11'd128;
    if (k == K_TICK) begin
      if (idle_count < tick_limit)
        idle_count = idle_count + 16'd1;
    end else begin
      // stale link: restart, flagging any packet in flight
      if (idle_count >= tick_limit) begin
        if (pstate != S_HUNT)
          add_event(EV_ABORT, 8'h00, 10'd0, blk_num, sz);
        pstate = S_HUNT;
      end
      idle_count = 16'd0;
      case (pstate)
        S_BLOCK: begin
          blk_num = b;
          pstate  = S_BLOCK_INV;
        end
        S_BLOCK_INV: begin
          pstate = (b == ~blk_num) ? S_PAYLOAD : S_HUNT;
        end
        S_PAYLOAD: begin
          add_event(EV_DATA, b, rx_count[9:0], blk_num, sz);
          crc_acc  = crc16_xmodem_byte(crc_acc, b);
          rx_count = rx_count + 11'd1;
          if (rx_count >= sz)
            pstate = S_CRC_MSB;
        end
        S_CRC_MSB: begin
          crc_hi = b;
          pstate = S_CRC_LSB;
        end
        S_CRC_LSB: begin
          add_event(({crc_hi, b} == crc_acc) ? EV_GOOD : EV_BAD,
                    8'h00, 10'd0, blk_num, sz);
          pstate = S_HUNT;
        end
        default: begin
          if (b == CODE_SOH || b == CODE_STX) begin
            long_blk = (b == CODE_STX);
            rx_count = 11'd0;
            crc_acc  = 16'h0000;
            pstate   = S_BLOCK;
          end else if (b == CODE_EOT) begin
            add_event(EV_EOT, 8'h00, 10'd0, 8'h00, 11'd0);
          end
        end
      endcase
      if (step_events.size() > 0)
        step_events[step_events.size() - 1].last = 1'b1;
    end
  endfunction

  // Present one beat, with an optional gap first, and wait for acceptance
  task automatic send_beat(input logic k, input logic [7:0] v);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    byte_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input logic k, input logic [7:0] v);
    send_beat(k, v);
    parse_beat(k, v);
    fed_items++;
    foreach (step_events[j])
      owed_events.push_back(step_events[j]);
  endtask

  // Drain, let in-flight beats settle, then write the timeout register
  task automatic write_timeout(input logic [15:0] v);
    in_valid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    cfg_valid     <= 1'b1;
    timeout_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    tick_limit  = v;
  endtask

  // Full frame with random payload; cut >= 0 stops after that many bytes
  task automatic send_packet(input bit long_frame, input int flaw, input int cut,
                             output int sent);
    logic [7:0]  frame [$];
    logic [7:0]  num;
    logic [7:0]  d;
    logic [15:0] crc;
    int          sz;
    int          i;
    int          n;
    num = 8'($urandom_range(0, 255));
    sz  = long_frame ? 1024 : 128;
    crc = 16'h0000;
    frame.push_back(long_frame ? CODE_STX : CODE_SOH);
    frame.push_back(num);
    frame.push_back(~num);
    repeat (sz) begin
      d   = 8'($urandom_range(0, 255));
      crc = crc16_xmodem_byte(crc, d);
      frame.push_back(d);
    end
    if (flaw == FLAW_CRC)
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    if (flaw == FLAW_DATA)
      frame[3 + $urandom_range(0, sz - 1)] ^= (8'h01 << $urandom_range(0, 7));
    i = 0;
    while (i < frame.size() && i != cut) begin
      // occasional idle ticks inside the frame, now and then a full timeout
      if ($urandom_range(0, 15) == 0) begin
        n = (tick_limit > 1) ? $urandom_range(0, (tick_limit > 4) ? 3 : tick_limit - 1) : 0;
        if (tick_limit <= 64 && $urandom_range(0, 19) == 0)
          n = tick_limit;
        repeat (n) feed(K_TICK, 8'($urandom_range(0, 255)));
      end
      feed(K_BYTE, frame[i]);
      i++;
    end
    sent = i;
  endtask

  // One random sequence: cut frames, plus EOT, noise, bad headers, ticks
  task automatic random_sequence();
    int          pick;
    int          f;
    int          cut;
    int          sent;
    logic [7:0]  num;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      f   = $urandom_range(0, 9);
      cut = $urandom_range(1, 40);
      send_packet($urandom_range(0, 3) == 0,
                  (f < 6) ? FLAW_NONE : (f < 8) ? FLAW_CRC : FLAW_DATA, cut, sent);
      if (tick_limit <= 64)
        repeat (tick_limit + $urandom_range(0, 2)) feed(K_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      feed(K_BYTE, CODE_EOT);
    end else if (pick < 72) begin
      repeat ($urandom_range(1, 6)) feed(K_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      num = 8'($urandom_range(0, 255));
      feed(K_BYTE, $urandom_range(0, 1) ? CODE_STX : CODE_SOH);
      feed(K_BYTE, num);
      feed(K_BYTE, ~num ^ 8'($urandom_range(1, 255)));
    end else if (pick < 92) begin
      repeat ($urandom_range(1, (tick_limit <= 64) ? tick_limit + 2 : 20))
        feed(K_TICK, 8'($urandom_range(0, 255)));
    end else begin
      feed(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver stall bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result beat with the oldest owed event
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_events.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual event %0d",
                 $time, event_res);
        mismatches++;
      end else begin
        want = owed_events.pop_front();
        check_field("event_res", want.event_res, event_res);
        check_field("data_byte", want.data_byte, data_byte);
        check_field("byte_index", want.byte_index, byte_index);
        check_field("packet_number", want.packet_number, packet_number);
        check_field("block_size", want.block_size, block_size);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ymodem_packet_parser_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned settings [6];
    int          sent;
    int          stop_at;
    res_t        r;
    dir_row_t    row;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NDIR; i++) begin
      row = DIR_ROWS[i];
      if (row.is_cfg) begin
        write_timeout(row.cfg_val);
      end else begin
        send_beat(row.kind, row.val);
        parse_beat(row.kind, row.val);
        if (!row.typed) begin
          foreach (step_events[j])
            owed_events.push_back(step_events[j]);
        end else if (row.one_res) begin
          r.event_res     = row.ev;
          r.data_byte     = 8'h00;
          r.byte_index    = 10'd0;
          r.packet_number = row.num;
          r.block_size    = row.size;
          r.last          = 1'b1;
          owed_events.push_back(r);
        end
      end
    end

    // Random part, one timeout setting per stretch; the last runs without gaps
    settings = '{1000, 1, 2, 65535, 7, 0};
    settings[5] = $urandom_range(3, 40);
    for (int p = 0; p < 6; p++) begin
      if (p == 5)
        calm = 1'b1;
      write_timeout(16'(settings[p]));
      if (p == 0) begin
        send_packet(1'b0, FLAW_NONE, -1, sent);
        send_packet(1'b0, FLAW_CRC, -1, sent);
      end
      stop_at = fed_items + STRETCH_ITEMS;
      while (fed_items < stop_at)
        random_sequence();
    end

    in_valid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("ymodem_packet_parser_top_tb: done, clean");
    else
      $display("ymodem_packet_parser_top_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
sv/ymp_pkg.sv
sv/ymp_parser.sv
sv/ymp_out_fifo.sv
sv/ymodem_packet_parser_top.sv
dv/ymodem_packet_parser_top_tb.sv
